[design/sdu_pkg.sv]
package sdu_pkg;

   // character codes
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_DOT = 8'h2E;

   // configuration register map
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam logic        REG_MAX_MSG = 1'b0;
   localparam logic [31:0] MAX_MSG_RESET = 32'd25000000;

   // result buffer sizing
   localparam int unsigned MAX_RESULTS = 5;
   localparam int unsigned CNT_W       = 3;

   // bytes held back while the terminator may still match, in release order
   localparam logic [7:0] HELD_BYTES [MAX_RESULTS] = '{CH_CR, CH_LF, CH_DOT, CH_CR, 8'h00};

   // match state, one-hot
   typedef enum logic [6:0] {
      ST_LINE    = 7'b0000001,
      ST_LDOT    = 7'b0000010,
      ST_MID     = 7'b0000100,
      ST_CR      = 7'b0001000,
      ST_CRLF    = 7'b0010000,
      ST_CRLFD   = 7'b0100000,
      ST_CRLFDCR = 7'b1000000
   } state_type;

endpackage

[design/smtp_data_dot_unstuffer.sv]
// SMTP data-phase dot unstuffer and end-of-data detector. Each req beat carries one raw
// byte of the data phase. A doubled dot at the start of a line loses one dot, and the
// terminator CR LF dot CR LF is found byte by byte: bytes that might belong to it are held
// and released in order once the match breaks, so the terminator itself never appears on
// rsp. A byte causes zero to five rsp beats; the last beat of a byte has tlast set. The
// terminator causes one beat with tuser end_of_message set, out_valid clear, data zero and
// rejected set if the raw byte count passed max_message_bytes (APB address 0, reset
// 25000000); from the byte that passes the limit until the terminator no data beats are
// sent, and the count restarts after each terminator. Rate: a byte is accepted in every
// cycle as long as rsp is ready and each byte gives at most one beat; a byte that gives
// n beats (held bytes released plus the byte itself) keeps the five-entry result buffer
// busy until all n have left, and the next byte enters in the cycle the last of those
// beats leaves. The first rsp beat of a byte is registered and comes the cycle after it.
module smtp_data_dot_unstuffer (
   input  logic                               clock,
   input  logic                               reset,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // [7:0] data_byte
   // result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [7:0]                         rsp_tdata,   // [7:0] out_byte
   output logic [2:0]                         rsp_tuser,   // [0] out_valid, [1] end_of_message,
                                                           // [2] rejected
   output logic                               rsp_tlast,   // run_last
   // configuration
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [sdu_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import sdu_pkg::*;

   // registers
   logic [31:0]            max_msg_ff;
   state_type              state_ff, state_in;
   logic [31:0]            count_ff, count_in;
   logic                   over_ff, over_in;
   logic [7:0]             buf_ff [MAX_RESULTS];
   logic [7:0]             buf_in [MAX_RESULTS];
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   eom_ff, eom_in;
   logic                   rej_ff, rej_in;

   // per-byte decode
   logic                   accept;
   logic                   pop;
   logic [7:0]             data;
   logic [CNT_W-1:0]       held_n;
   logic                   emit_b;
   logic                   eom_det;
   logic                   over_now;
   logic [31:0]            count_sat;
   logic [CNT_W-1:0]       res_n;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1] == REG_MAX_MSG) ? max_msg_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_msg_ff <= MAX_MSG_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr[CSR_ADDR_W-1] == REG_MAX_MSG) begin
         max_msg_ff <= csr_pwdata;
      end
   end

   // handshake: take a byte once the buffer empties this cycle
   assign pop        = rsp_tvalid && rsp_tready;
   assign req_tready = (cnt_ff == '0) || (cnt_ff == CNT_W'(1) && rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign data       = req_tdata;

   // saturating byte count and limit test
   assign count_sat = (count_ff == '1) ? count_ff : count_ff + 32'd1;
   assign over_now  = over_ff || (count_sat > max_msg_ff);

   // match state machine: held bytes to release, whether this byte goes out, next state
   always_comb begin
      held_n   = '0;
      emit_b   = 1'b0;
      eom_det  = 1'b0;
      state_in = ST_MID;
      case (state_ff)
         ST_LINE: begin
            if (data == CH_DOT) begin
               emit_b   = 1'b1;
               state_in = ST_LDOT;
            end
         end
         ST_LDOT: begin
            if (data == CH_DOT) begin
               state_in = ST_MID;
            end
         end
         ST_CR: begin
            if (data == CH_LF) begin
               state_in = ST_CRLF;
            end else begin
               held_n = CNT_W'(1);
            end
         end
         ST_CRLF: begin
            if (data == CH_DOT) begin
               state_in = ST_CRLFD;
            end else begin
               held_n = CNT_W'(2);
            end
         end
         ST_CRLFD: begin
            if (data == CH_CR) begin
               state_in = ST_CRLFDCR;
            end else begin
               held_n = CNT_W'(3);
            end
         end
         ST_CRLFDCR: begin
            if (data == CH_LF) begin
               eom_det  = 1'b1;
               state_in = ST_LINE;
            end else begin
               held_n = CNT_W'(4);
            end
         end
         default: begin
         end
      endcase

      // ordinary byte handling where no special transition was taken
      if (!eom_det && !emit_b
          && !(state_ff == ST_LDOT && data == CH_DOT)
          && !(state_ff == ST_CR && data == CH_LF)
          && !(state_ff == ST_CRLF && data == CH_DOT)
          && !(state_ff == ST_CRLFD && (data == CH_DOT || data == CH_CR))) begin
         if (data == CH_CR) begin
            state_in = ST_CR;
         end else if (data == CH_LF) begin
            emit_b   = 1'b1;
            state_in = ST_LINE;
         end else begin
            emit_b   = 1'b1;
            state_in = ST_MID;
         end
      end
   end

   assign res_n = held_n + {{(CNT_W-1){1'b0}}, emit_b};

   // result buffer load and drain
   always_comb begin
      for (int k = 0; k < MAX_RESULTS; k++) begin
         if (pop) begin
            buf_in[k] = (k < MAX_RESULTS - 1) ? buf_ff[(k + 1) % MAX_RESULTS] : 8'h00;
         end else begin
            buf_in[k] = buf_ff[k];
         end
      end
      cnt_in   = pop ? cnt_ff - CNT_W'(1) : cnt_ff;
      eom_in   = eom_ff;
      rej_in   = rej_ff;
      count_in = count_ff;
      over_in  = over_ff;
      if (accept) begin
         count_in = count_sat;
         over_in  = over_now;
         eom_in   = 1'b0;
         rej_in   = 1'b0;
         for (int k = 0; k < MAX_RESULTS; k++) begin
            buf_in[k] = (CNT_W'(k) < held_n) ? HELD_BYTES[k] : data;
         end
         if (eom_det) begin
            buf_in[0] = 8'h00;
            cnt_in    = CNT_W'(1);
            eom_in    = 1'b1;
            rej_in    = over_now;
            count_in  = '0;
            over_in   = 1'b0;
         end else if (over_now) begin
            cnt_in = '0;
         end else begin
            cnt_in = res_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LINE;
         count_ff <= '0;
         over_ff  <= 1'b0;
         cnt_ff   <= '0;
         eom_ff   <= 1'b0;
         rej_ff   <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         count_ff <= count_in;
         over_ff  <= over_in;
         cnt_ff   <= cnt_in;
         eom_ff   <= eom_in;
         rej_ff   <= rej_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   // result beat
   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tdata  = buf_ff[0];
   assign rsp_tuser  = {rej_ff, eom_ff, ~eom_ff};
   assign rsp_tlast  = (cnt_ff == CNT_W'(1));

`ifndef SYNTHESIS
   // an end-of-message beat stands alone
   a_eom_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && eom_ff |-> rsp_tlast)
      else $error("end-of-message beat is not the last of its run");

   // the result buffer never holds more than a byte can cause
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_RESULTS))
      else $error("result buffer count out of range");

   // a terminator restarts matching and counting
   a_eom_restart: assert property (@(posedge clock) disable iff (reset)
      accept && eom_det |=> state_ff == ST_LINE && count_ff == '0 && !over_ff)
      else $error("state not restarted after terminator");

   // rejected only on an end-of-message beat
   a_rej_eom: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rej_ff |-> eom_ff)
      else $error("rejected flag on a data beat");

   // no data beat while the message is over the limit
   a_over_quiet: assert property (@(posedge clock) disable iff (reset)
      accept && over_now && !eom_det |=> cnt_ff == '0)
      else $error("data released while oversize");
`endif

endmodule
